@@ rtl/core/avc_pkg.sv @@
// Package for the atom valence checker: element codes, verdict codes,
// grading windows, the queue item type and the allowed valence lookup.
// No dependencies.
`default_nettype none

package avc_pkg;

  // element codes
  localparam logic [4:0] EL_H        = 5'd0;
  localparam logic [4:0] EL_B        = 5'd1;
  localparam logic [4:0] EL_C        = 5'd2;
  localparam logic [4:0] EL_N        = 5'd3;
  localparam logic [4:0] EL_O        = 5'd4;
  localparam logic [4:0] EL_F        = 5'd5;
  localparam logic [4:0] EL_SI       = 5'd6;
  localparam logic [4:0] EL_P        = 5'd7;
  localparam logic [4:0] EL_S        = 5'd8;
  localparam logic [4:0] EL_CL       = 5'd9;
  localparam logic [4:0] EL_SE       = 5'd10;
  localparam logic [4:0] EL_BR       = 5'd11;
  localparam logic [4:0] EL_I        = 5'd12;
  localparam logic [4:0] EL_METAL_LO = 5'd13;

  // formal charges with their own valence lists
  localparam logic signed [3:0] CHARGE_POS = 4'sd1;
  localparam logic signed [3:0] CHARGE_NEG = -4'sd1;

  // aromatic acceptance windows, total in half units
  localparam logic [6:0] AROM_C_LO = 7'd7;
  localparam logic [6:0] AROM_C_HI = 7'd11;
  localparam logic [6:0] AROM_N_LO = 7'd5;
  localparam logic [6:0] AROM_N_HI = 7'd9;

  // warning limits, total in half units
  localparam logic [6:0] WARN_S_MAX = 7'd13;
  localparam logic [6:0] WARN_P_MAX = 7'd11;
  localparam logic [6:0] WARN_N_MAX = 7'd11;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    VERDICT_VALID   = 2'd0,
    VERDICT_WARNING = 2'd1,
    VERDICT_ERROR   = 2'd2
  } verdict_t;

  // element class bits needed by grading
  typedef struct packed {
    logic is_c;
    logic is_n;
    logic is_p;
    logic is_s;
    logic arom;
    logic charge_nonneg;
  } atom_kind_t;

  // one classified atom as it travels through the queue
  typedef struct packed {
    logic [2:0] hydrogens;
    logic [6:0] total;
    logic [7:0] val_mask;   // bit v set when valence v is allowed
    atom_kind_t kind;
    logic       last;
  } atom_item_t;

  // allowed valences as a bit mask, ascending bit order matches list order
  function automatic logic [7:0] valence_mask(input logic [4:0] el,
                                              input logic signed [3:0] q);
    logic pos;
    logic neg;
    logic [7:0] m;
    pos = (q == CHARGE_POS);
    neg = (q == CHARGE_NEG);
    case (el)
      EL_H:  m = 8'b0000_0010;
      EL_B:  m = neg ? 8'b0001_0000 : 8'b0000_1000;
      EL_C:  m = (pos || neg) ? 8'b0000_1000 : 8'b0001_0000;
      EL_N:  m = pos ? 8'b0001_0000 : (neg ? 8'b0000_0100 : 8'b0010_1000);
      EL_O:  m = pos ? 8'b0000_1000 : (neg ? 8'b0000_0010 : 8'b0000_1100);
      EL_F:  m = 8'b0000_0010;
      EL_SI: m = 8'b0001_0000;
      EL_P:  m = pos ? 8'b0001_0000 : 8'b0010_1000;
      EL_S:  m = pos ? 8'b0000_1000 : (neg ? 8'b0000_0010 : 8'b0101_1100);
      EL_CL,
      EL_I:  m = neg ? 8'b0000_0001 : 8'b1010_1010;
      EL_SE: m = 8'b0101_0100;
      EL_BR: m = neg ? 8'b0000_0001 : 8'b0010_1010;
      default: m = 8'b0111_1111;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/avc_atom_if.sv @@
// Atom input channel: valid/ready handshake with the atom fields.
// Depends on nothing.
`default_nettype none

interface avc_atom_if;
  logic              valid;
  logic              ready;
  logic [4:0]        element;
  logic signed [3:0] charge;
  logic [5:0]        bond_halves;
  logic              aromatic;
  logic [2:0]        given_hydrogens;
  logic              last_atom;

  modport source (output valid, element, charge, bond_halves, aromatic,
                  given_hydrogens, last_atom, input ready);
  modport sink   (input valid, element, charge, bond_halves, aromatic,
                  given_hydrogens, last_atom, output ready);
endinterface

`default_nettype wire

@@ rtl/core/avc_result_if.sv @@
// Result channel: valid/ready handshake with the graded atom fields.
// Depends on nothing.
`default_nettype none

interface avc_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] hydrogens_used;
  logic [6:0] total_halves;
  logic [1:0] verdict;
  logic [2:0] nearest_valence;
  logic       molecule_valid;
  logic       molecule_end;

  modport source (output valid, hydrogens_used, total_halves, verdict,
                  nearest_valence, molecule_valid, molecule_end, input ready);
  modport sink   (input valid, hydrogens_used, total_halves, verdict,
                  nearest_valence, molecule_valid, molecule_end, output ready);
endinterface

`default_nettype wire

@@ rtl/core/avc_front.sv @@
// Front end: takes atom beats, looks up the valence list, infers hydrogens
// and forms the total. Depends on avc_pkg and avc_atom_if.
`default_nettype none

module avc_front (
  avc_atom_if.sink           atoms,
  output logic               push_valid,
  input  logic               push_ready,
  output avc_pkg::atom_item_t push_item
);

  logic [7:0] mask;
  logic       no_h;
  logic       found;
  logic [2:0] h_inf;
  logic [2:0] h_used;
  logic [6:0] diff;

  // handshake passes straight to the queue
  assign push_valid  = atoms.valid;
  assign atoms.ready = push_ready;

  assign mask = avc_pkg::valence_mask(atoms.element, atoms.charge);
  assign no_h = (atoms.element == avc_pkg::EL_H) ||
                (atoms.element >= avc_pkg::EL_METAL_LO);

  // first allowed valence at or above the bond sum, rounded half up
  always_comb begin
    found = 1'b0;
    h_inf = 3'd0;
    diff  = 7'd0;
    for (int v = 0; v < 8; v++) begin
      if (!found && mask[v] && (7'(2 * v) >= {1'b0, atoms.bond_halves})) begin
        diff  = 7'(2 * v) - {1'b0, atoms.bond_halves} + 7'd1;
        h_inf = diff[3:1];
        found = 1'b1;
      end
    end
  end

  assign h_used = (atoms.given_hydrogens == 3'd0 && !no_h) ? h_inf
                                                           : atoms.given_hydrogens;

  // classified item
  always_comb begin
    push_item.hydrogens          = h_used;
    push_item.total              = {1'b0, atoms.bond_halves} + {3'd0, h_used, 1'b0};
    push_item.val_mask           = mask;
    push_item.kind.is_c          = (atoms.element == avc_pkg::EL_C);
    push_item.kind.is_n          = (atoms.element == avc_pkg::EL_N);
    push_item.kind.is_p          = (atoms.element == avc_pkg::EL_P);
    push_item.kind.is_s          = (atoms.element == avc_pkg::EL_S);
    push_item.kind.arom          = atoms.aromatic;
    push_item.kind.charge_nonneg = !atoms.charge[3];
    push_item.last               = atoms.last_atom;
  end

endmodule

`default_nettype wire

@@ rtl/core/avc_queue.sv @@
// Short register queue between front and back, push and pop in the same cycle.
// Depends on avc_pkg.
`default_nettype none

module avc_queue #(
  parameter int DEPTH = avc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  avc_pkg::atom_item_t push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output avc_pkg::atom_item_t pop_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL      = CW'(DEPTH);

  avc_pkg::atom_item_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/avc_back.sv @@
// Back end: tests the total against the valence list, grades the atom,
// finds the nearest valence and keeps the molecule flag.
// Depends on avc_pkg and avc_result_if.
`default_nettype none

module avc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  avc_pkg::atom_item_t pop_item,
  avc_result_if.source        results
);

  logic              out_valid;
  logic [2:0]        hyd;
  logic [6:0]        total;
  avc_pkg::verdict_t verdict;
  logic [2:0]        nearest;
  logic              mol_valid;
  logic              mol_end;
  logic              molecule_ok;

  logic              in_list;
  logic              ok;
  logic              warn;
  logic [5:0]        r;
  logic [5:0]        d;
  logic [5:0]        best;
  logic              have;
  logic [2:0]        near_sel;
  avc_pkg::verdict_t verdict_next;
  logic              mol_valid_next;
  logic              take;

  assign pop_ready = !out_valid || results.ready;
  assign take      = pop_valid && pop_ready;

  // total within one half unit of an allowed valence
  always_comb begin
    in_list = 1'b0;
    for (int v = 0; v < 8; v++) begin
      if (pop_item.val_mask[v] &&
          ({1'b0, pop_item.total} + 8'd1 >= 8'(2 * v)) &&
          ({1'b0, pop_item.total} <= 8'(2 * v + 1))) begin
        in_list = 1'b1;
      end
    end
  end

  // aromatic windows
  assign ok = in_list ||
    (pop_item.kind.arom && pop_item.kind.is_c &&
     pop_item.total >= avc_pkg::AROM_C_LO && pop_item.total <= avc_pkg::AROM_C_HI) ||
    (pop_item.kind.arom && pop_item.kind.is_n &&
     pop_item.total >= avc_pkg::AROM_N_LO && pop_item.total <= avc_pkg::AROM_N_HI);

  // nearest allowed valence to the rounded total, lower valence wins ties
  assign r = 6'((8'({1'b0, pop_item.total}) + 8'd1) >> 1);
  always_comb begin
    have     = 1'b0;
    best     = '0;
    near_sel = '0;
    d        = '0;
    for (int v = 0; v < 8; v++) begin
      d = (6'(v) > r) ? 6'(v) - r : r - 6'(v);
      if (pop_item.val_mask[v] && (!have || d < best)) begin
        best     = d;
        near_sel = 3'(v);
        have     = 1'b1;
      end
    end
  end

  // S/P/N warning rules
  assign warn = (pop_item.kind.is_s && pop_item.total <= avc_pkg::WARN_S_MAX) ||
                (pop_item.kind.is_p && pop_item.total <= avc_pkg::WARN_P_MAX) ||
                (pop_item.kind.is_n && pop_item.total <= avc_pkg::WARN_N_MAX &&
                 pop_item.kind.charge_nonneg);

  always_comb begin
    if (ok) begin
      verdict_next = avc_pkg::VERDICT_VALID;
    end else if (warn) begin
      verdict_next = avc_pkg::VERDICT_WARNING;
    end else begin
      verdict_next = avc_pkg::VERDICT_ERROR;
    end
  end

  assign mol_valid_next = molecule_ok && (verdict_next != avc_pkg::VERDICT_ERROR);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hyd       <= pop_item.hydrogens;
      total     <= pop_item.total;
      verdict   <= verdict_next;
      nearest   <= ok ? 3'd0 : near_sel;
      mol_valid <= mol_valid_next;
      mol_end   <= pop_item.last;
    end
  end

  // sticky molecule flag, set again after the last atom
  always_ff @(posedge clk) begin
    if (rst) begin
      molecule_ok <= 1'b1;
    end else if (take) begin
      molecule_ok <= pop_item.last ? 1'b1 : mol_valid_next;
    end
  end

  assign results.valid           = out_valid;
  assign results.hydrogens_used  = hyd;
  assign results.total_halves    = total;
  assign results.verdict         = verdict;
  assign results.nearest_valence = nearest;
  assign results.molecule_valid  = mol_valid;
  assign results.molecule_end    = mol_end;

endmodule

`default_nettype wire

@@ rtl/core/atom_valence_checker_unit.sv @@
// Atom valence checker top level: front end, queue and back end.
// Depends on avc_pkg, avc_atom_if, avc_result_if, avc_front, avc_queue, avc_back.
//
// Usage:
//   atoms carries one atom per beat (element, charge, bond sum in half units,
//   aromatic flag, given hydrogen count, last-atom mark); results carries one
//   graded beat per atom, in order.
//   Path: an atom taken on atoms is written into a queue slot and then graded
//   into the back end's output register, which drives results.
//   Throughput: one atom per cycle while results does not stall; the front end
//   is combinational lookup logic and the back end combinational grading logic.
//   When results stalls, the back end holds its output register and the queue
//   (DEPTH beats) fills; atoms.ready falls once the queue is full.
//   Reset empties the queue and the output register and sets the molecule
//   flag to valid. The flag is cleared by any error and set again after the
//   atom marked last.
`default_nettype none

module atom_valence_checker_unit #(
  parameter int DEPTH = avc_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  avc_atom_if.sink     atoms,
  avc_result_if.source results
);

  logic                push_valid;
  logic                push_ready;
  avc_pkg::atom_item_t push_item;
  logic                pop_valid;
  logic                pop_ready;
  avc_pkg::atom_item_t pop_item;

  avc_front u_front (
    .atoms      (atoms),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  avc_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  avc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .results   (results)
  );

endmodule

`default_nettype wire
